[design/hrti_pkg.sv]
// ----------------------------------------------------------------------------
// hrti_pkg
// shared types, sizes and codes for the hashed radix trie index
// ----------------------------------------------------------------------------
package hrti_pkg;

    // trie sizing
    localparam int NODE_COUNT = 1024;
    localparam int FANOUT     = 16;
    localparam int HASH_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int DATA_BITS  = 32;

    localparam int LEVELS     = HASH_BITS / 4;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int NIB_W      = $clog2(FANOUT);
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = NODE_W + 1;
    localparam int LINK_DEPTH = NODE_COUNT * FANOUT;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    // request type codes
    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // request beat
    typedef struct packed {
        logic                        req_type;
        logic [HASH_BITS-1:0]        key_hash;
        logic signed [DATA_BITS-1:0] write_data;
    } t_req;

    // result beat
    typedef struct packed {
        t_status                     status;
        logic signed [DATA_BITS-1:0] read_data;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic    clr;
        logic    load;
        logic    rd_link;
        logic    alloc;
        logic    step;
        logic    rd_leaf;
        logic    wr_leaf;
        logic    rsp_load;
        t_status rsp_st;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic link_null;
        logic last_level;
        logic pool_full;
        logic is_get;
    } t_sts;

endpackage

[design/hrti_datapath.sv]
// ----------------------------------------------------------------------------
// hrti_datapath
// link and leaf stores, walk registers, node allocator and result register
// ----------------------------------------------------------------------------
module hrti_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hrti_pkg::t_req i_req,
    input  hrti_pkg::t_cmd i_cmd,
    output hrti_pkg::t_sts o_sts,
    output hrti_pkg::t_rsp o_rsp
);
    import hrti_pkg::*;

    // stores
    logic [NODE_W-1:0]            r_link_mem [LINK_DEPTH];
    logic signed [VALUE_BITS-1:0] r_leaf_mem [NODE_COUNT];

    // walk state
    t_req                         r_req;
    logic [NODE_W-1:0]            r_node;
    logic [LVL_W-1:0]             r_level;
    logic [FREE_W-1:0]            r_free;
    logic [LINK_AW-1:0]           r_clr_cnt;
    logic [NODE_W-1:0]            r_link_q;
    logic signed [VALUE_BITS-1:0] r_leaf_q;
    t_rsp                         r_rsp;

    logic [4:0]                   w_shift;
    logic [NIB_W-1:0]             w_nib;
    logic [LINK_AW-1:0]           w_link_addr;
    logic signed [63:0]           w_wr_ext;
    logic signed [63:0]           w_rd_ext;

    // nibble order: high nibble of each byte first, bytes little-endian
    assign w_shift     = {r_level[2:1], ~r_level[0], 2'b00};
    assign w_nib       = NIB_W'(r_req.key_hash >> w_shift);
    assign w_link_addr = {r_node, w_nib};

    // value width conversion on store and load
    assign w_wr_ext = 64'(r_req.write_data);
    assign w_rd_ext = 64'(r_leaf_q);

    // control registers: allocator and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= FREE_W'(1);
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + LINK_AW'(1);
            end
            if (i_cmd.alloc) begin
                r_free <= r_free + FREE_W'(1);
            end
        end
    end

    // request capture and walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_node  <= '0;
            r_level <= '0;
        end else if (i_cmd.step) begin
            r_node  <= i_cmd.alloc ? r_free[NODE_W-1:0] : r_link_q;
            r_level <= r_level + LVL_W'(1);
        end
    end

    // link store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_link_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.alloc) begin
            r_link_mem[w_link_addr] <= r_free[NODE_W-1:0];
        end
        if (i_cmd.rd_link) begin
            r_link_q <= r_link_mem[w_link_addr];
        end
    end

    // leaf store: cleared during the sweep, one row per sixteen link slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_leaf_mem[r_clr_cnt[LINK_AW-1:NIB_W]] <= '0;
        end else if (i_cmd.wr_leaf) begin
            r_leaf_mem[r_node] <= w_wr_ext[VALUE_BITS-1:0];
        end
        if (i_cmd.rd_leaf) begin
            r_leaf_q <= r_leaf_mem[r_node];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) begin
            r_rsp.status <= i_cmd.rsp_st;
            if (i_cmd.rsp_st == ST_OK && r_req.req_type == REQ_GET) begin
                r_rsp.read_data <= w_rd_ext[DATA_BITS-1:0];
            end else begin
                r_rsp.read_data <= '0;
            end
        end
    end

    // status back to the controller
    assign o_sts.clr_last   = (r_clr_cnt == LINK_AW'(LINK_DEPTH - 1));
    assign o_sts.link_null  = (r_link_q == '0);
    assign o_sts.last_level = (r_level == LVL_W'(LEVELS - 1));
    assign o_sts.pool_full  = (r_free >= FREE_W'(NODE_COUNT));
    assign o_sts.is_get     = (r_req.req_type == REQ_GET);

    assign o_rsp = r_rsp;

endmodule

[design/hrti_ctrl.sv]
// ----------------------------------------------------------------------------
// hrti_ctrl
// sequencer for clearing, trie walk, leaf access and result handoff
// ----------------------------------------------------------------------------
module hrti_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  hrti_pkg::t_sts i_sts,
    output hrti_pkg::t_cmd o_cmd
);
    import hrti_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK_RD,
        S_LINK_CHK,
        S_LEAF,
        S_LEAF_WAIT,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;
    logic    r_out_valid, n_out_valid;
    logic    w_out_free;
    t_cmd    w_cmd;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        w_cmd       = '0;
        w_cmd.rsp_st = r_st;
        n_state     = r_state;
        n_st        = r_st;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_LINK_RD;
                end
            end
            S_LINK_RD: begin
                w_cmd.rd_link = 1'b1;
                n_state       = S_LINK_CHK;
            end
            S_LINK_CHK: begin
                if (i_sts.link_null && i_sts.is_get) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else if (i_sts.link_null && i_sts.pool_full) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    w_cmd.alloc = i_sts.link_null;
                    w_cmd.step  = 1'b1;
                    n_state     = i_sts.last_level ? S_LEAF : S_LINK_RD;
                end
            end
            S_LEAF: begin
                n_st = ST_OK;
                if (i_sts.is_get) begin
                    w_cmd.rd_leaf = 1'b1;
                    n_state       = S_LEAF_WAIT;
                end else begin
                    w_cmd.wr_leaf = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_LEAF_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_cmd.rsp_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_st        <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    // a result beat only appears when a finished request is handed over
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the handoff state");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rsp_load |-> (!r_out_valid || !i_out_stall))
        else $error("result register loaded while a beat is stalled");

    // no node is handed out once the pool is spent
    a_alloc_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.alloc |-> (!i_sts.pool_full && !i_sts.is_get))
        else $error("node allocated with pool exhausted or on a get");

    // leaf writes only on a set that walked all levels
    a_leaf_wr_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_leaf |-> (!i_sts.is_get && $past(r_state == S_LINK_CHK)))
        else $error("leaf written outside a completed set walk");

    // reset always starts the clearing sweep
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR && !r_out_valid))
        else $error("reset did not start the clearing sweep");
`endif

endmodule

[design/hashed_radix_trie_index_top.sv]
// ----------------------------------------------------------------------------
// hashed_radix_trie_index_top
// each trie level is a link store read, then a check and optional link write;
// eight levels per request, and a miss or a full pool ends the walk early.
// only one request is in flight at a time.
// reset: a sweep clears the link and leaf stores with input stalled.
// ----------------------------------------------------------------------------
module hashed_radix_trie_index_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hrti_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hrti_pkg::t_rsp o_out
);
    import hrti_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    hrti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // stores and walk datapath
    hrti_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_out)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hashed radix trie index: a scoreboard model
// of the trie walks each accepted request, and every result beat is compared
// against the oldest pending prediction under random gaps, stalls and one
// long output hold; the run drives the node pool to exhaustion
// ----------------------------------------------------------------------------
module tb_top;
    import hrti_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 65536;   // longer than the reset sweep
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 40;

    // dut connections
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out;

    // scoreboard model of the trie
    logic [NODE_W-1:0]           trie_links [LINK_DEPTH];
    logic signed [VALUE_BITS-1:0] trie_leaf [NODE_COUNT];
    int                          trie_next_free;

    // pending predictions and keys known to be stored
    t_rsp                 lookup_results_q [$];
    logic [HASH_BITS-1:0] known_keys [$];

    int fail_count = 0;
    int idle_cycles = 0;
    bit quiet_tail;
    bit hold_req;

    hashed_radix_trie_index_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // nibble used at a given trie level, low byte first, high nibble first
    function automatic logic [NIB_W-1:0] key_nibble(input logic [HASH_BITS-1:0] h,
                                                    input int lvl);
        int sh;
        sh = 8 * (lvl / 2) + ((lvl % 2) ? 0 : 4);
        return NIB_W'(h >> sh);
    endfunction

    // walk the model trie for one request and update it as the block would
    function automatic t_rsp trie_walk(input t_req req);
        t_rsp res;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] nxt;
        int slot;
        int lvl;
        res.status    = ST_OK;
        res.read_data = '0;
        node = '0;
        for (lvl = 0; lvl < LEVELS; lvl++) begin
            slot = int'(node) * FANOUT + int'(key_nibble(req.key_hash, lvl));
            nxt  = trie_links[slot];
            if (nxt == '0) begin
                if (req.req_type == REQ_GET) begin
                    res.status = ST_NOT_FOUND;
                    return res;
                end
                // allocate a fresh node, or give up with the pool spent
                if (trie_next_free >= NODE_COUNT) begin
                    res.status = ST_FULL;
                    return res;
                end
                nxt = NODE_W'(trie_next_free);
                trie_next_free++;
                trie_links[slot] = nxt;
            end
            node = nxt;
        end
        if (req.req_type == REQ_GET)
            res.read_data = trie_leaf[node];
        else
            trie_leaf[node] = req.write_data;
        return res;
    endfunction

    // offer one request, hold it until taken, then record its prediction
    task automatic send_req(input logic rtype, input logic [HASH_BITS-1:0] hash,
                            input logic signed [DATA_BITS-1:0] wdata);
        t_req req;
        t_rsp res;
        int gap;
        req.req_type   = rtype;
        req.key_hash   = hash;
        req.write_data = wdata;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        res = trie_walk(req);
        lookup_results_q.push_back(res);
        if (rtype == REQ_SET && res.status == ST_OK)
            known_keys.push_back(hash);
    endtask

    // value with a bias towards the extremes
    function automatic logic signed [DATA_BITS-1:0] pick_data();
        case ($urandom_range(0, 11))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [HASH_BITS-1:0] pick_known();
        if (known_keys.size() == 0)
            return $urandom;
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // one random request, mostly along paths that already exist
    task automatic random_item();
        logic [HASH_BITS-1:0] k;
        int lvl;
        int sh;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_req(REQ_GET, pick_known(), pick_data());
        end else if (r < 40) begin
            // known key with one nibble changed, misses at a random depth
            k   = pick_known();
            lvl = $urandom_range(0, LEVELS - 1);
            sh  = 8 * (lvl / 2) + ((lvl % 2) ? 0 : 4);
            k   = k ^ (HASH_BITS'($urandom_range(1, 15)) << sh);
            send_req(REQ_GET, k, pick_data());
        end else if (r < 60) begin
            send_req(REQ_SET, pick_known(), pick_data());
        end else if (r < 85) begin
            // sibling of a known key: only the two deepest levels differ
            k = pick_known();
            k[31:24] = 8'($urandom);
            send_req(REQ_SET, k, pick_data());
        end else if (r < 93) begin
            send_req(REQ_SET, $urandom, pick_data());
        end else begin
            send_req(REQ_GET, $urandom, pick_data());
        end
    endtask

    // result side stall: random bursts, one long hold on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want_v, got_v);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lookup_results_q.size() == 0) begin
                report_mismatch("unexpected beat", '0, o_out.read_data);
            end else begin
                want = lookup_results_q.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_out.status));
                if (o_out.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, o_out.read_data);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("[hashed_radix_trie_index_top] ERROR");
            $finish;
        end
    end

    // empty trie: nothing to find
    task automatic test_empty_lookup();
        send_req(REQ_GET, 32'h0000_0000, '0);
        send_req(REQ_GET, 32'hffff_ffff, -32'sd1);
    endtask

    // key and value extremes
    task automatic test_field_extremes();
        send_req(REQ_SET, 32'h0000_0000, 32'sh7fffffff);
        send_req(REQ_GET, 32'h0000_0000, '0);
        send_req(REQ_SET, 32'hffff_ffff, 32'sh80000000);
        send_req(REQ_GET, 32'hffff_ffff, -32'sd1);
        send_req(REQ_SET, 32'h1234_5678, '0);
        send_req(REQ_GET, 32'h1234_5678, 32'sh5a5a5a5a);
    endtask

    // set on an existing key replaces the leaf without new nodes
    task automatic test_overwrite();
        send_req(REQ_SET, 32'h0000_0000, -32'sd1);
        send_req(REQ_GET, 32'h0000_0000, '0);
        send_req(REQ_SET, 32'h0000_0000, 32'sd1);
        send_req(REQ_GET, 32'h0000_0000, '0);
    endtask

    // misses that leave a stored path at the second, seventh and last level
    task automatic test_prefix_miss();
        send_req(REQ_GET, 32'h0000_000f, '0);
        send_req(REQ_GET, 32'hf000_0000, '0);
        send_req(REQ_GET, 32'h0f00_0000, '0);
        send_req(REQ_SET, 32'h0f00_0000, 32'sh5a5a5a5a);
        send_req(REQ_GET, 32'h0f00_0000, '0);
        send_req(REQ_GET, 32'h0000_0000, '0);
    endtask

    task automatic test_random_traffic();
        repeat (780) random_item();
    endtask

    // long output hold while requests keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (24) random_item();
    endtask

    // spend the node pool, then check that full sets keep their partial paths
    task automatic test_pool_exhaustion();
        logic [HASH_BITS-1:0] failed_keys [$];
        logic [HASH_BITS-1:0] k;
        int guard;
        guard = 0;
        while (trie_next_free < NODE_COUNT && guard < 400) begin
            send_req(REQ_SET, $urandom, pick_data());
            guard++;
        end
        repeat (12) begin
            k = $urandom;
            failed_keys.push_back(k);
            send_req(REQ_SET, k, pick_data());
        end
        send_req(REQ_SET, pick_known(), pick_data());
        foreach (failed_keys[i])
            send_req(REQ_GET, failed_keys[i], '0);
        repeat (8) send_req(REQ_GET, pick_known(), '0);
    endtask

    // closing stretch with no gaps and no stalls
    task automatic test_quiet_tail();
        quiet_tail = 1'b1;
        repeat (200) random_item();
    endtask

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        quiet_tail     = 1'b0;
        hold_req       = 1'b0;
        trie_next_free = 1;
        foreach (trie_links[i]) trie_links[i] = '0;
        foreach (trie_leaf[i]) trie_leaf[i] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookup();
        test_field_extremes();
        test_overwrite();
        test_prefix_miss();
        test_random_traffic();
        test_backpressure();
        test_pool_exhaustion();
        test_quiet_tail();

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain outstanding results, then allow for stray beats
        while (lookup_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && lookup_results_q.size() == 0)
            $display("[hashed_radix_trie_index_top] OK");
        else
            $display("[hashed_radix_trie_index_top] ERROR");
        $finish;
    end

endmodule
